// ===== hw/rtl/prqs_pkg.sv =====
// Shared types and constants for the priority ready queue scheduler.
package prqs_pkg;

	typedef enum logic [2:0] {
		MODE_ADD    = 3'd0,
		MODE_REMOVE = 3'd1,
		MODE_DELETE = 3'd2,
		MODE_CHANGE = 3'd3,
		MODE_QUERY  = 3'd4,
		MODE_INIT   = 3'd5
	} mode_t;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_NOT_QUEUED = 2'd1;
	localparam logic [1:0] STATUS_QUEUED     = 2'd2;

	localparam logic [1:0] COND_WAIT    = 2'd0;
	localparam logic [1:0] COND_READY   = 2'd1;
	localparam logic [1:0] COND_DORMANT = 2'd3;

	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 16;
	localparam int PADDR_W   = 3;

	localparam logic       REG_INIT_PRIO   = 1'b0;
	localparam logic [7:0] INIT_PRIO_RESET = 8'd233;

endpackage

// ===== hw/rtl/prqs_cfg_regs.sv =====
// Configuration register bank with an APB-style access port.
module prqs_cfg_regs
	import prqs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [7:0]         init_prio
);

	logic [7:0] init_prio_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_prio_q <= INIT_PRIO_RESET;
		end else if (wr_en && paddr[2] == REG_INIT_PRIO) begin
			init_prio_q <= pwdata[7:0];
		end
	end

	assign prdata    = (paddr[2] == REG_INIT_PRIO) ? {24'd0, init_prio_q} : 32'd0;
	assign init_prio = init_prio_q;

endmodule

// ===== hw/rtl/priority_ready_queue_scheduler_unit.sv =====
// Top level: per-level FIFO ready queues of tasks, run by a small link sequencer.
//
//  channel  | dir | transfer when               | payload
//  ---------+-----+-----------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid & tready      | mode, task_id, new_priority
//  m_axis   | out | m_axis_tvalid & tready      | status, top_priority, head_task,
//           |     |                             | head_valid, task_state
//  apb      | in  | psel & penable & pwrite     | initial_priorities at word 0
//
//  One command at a time: decode, up to two link steps, a level scan of one level per
//  cycle, then the result register. Init appends every task in turn in place of the
//  link steps. The shared link unit does one append or one unlink per cycle.
//  s_axis_tready is high only when idle, which starts as the result is loaded; a full
//  output register holds the command in its last step. Reset empties every queue.
module priority_ready_queue_scheduler_unit
	import prqs_pkg::*;
#(
	parameter int NUM_TASKS  = 4,
	parameter int NUM_LEVELS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [2:0] mode, [4:3] task_id, [6:5] new_priority, [7] zero
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [1:0] status, [3:2] top_priority, [5:4] head_task, [6] head_valid,
	// [8:7] task_state, [15:9] zero
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int TW = $clog2(NUM_TASKS);
	localparam int LW = $clog2(NUM_TASKS + 1);
	localparam int VW = $clog2(NUM_LEVELS);
	localparam logic [LW-1:0] NONE     = LW'(NUM_TASKS);
	localparam logic [TW-1:0] LAST_TSK = TW'(NUM_TASKS - 1);
	localparam logic [VW-1:0] TOP_LVL  = VW'(NUM_LEVELS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_INIT_APP,
		ST_UNLINK,
		ST_APPEND,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [2:0]             mode_q;
	logic [TW-1:0]          tsk_q;
	logic                   tsk_ok_q;
	logic [VW-1:0]          np_q;
	logic [VW-1:0]          app_lvl_q;
	logic [TW-1:0]          app_q;
	logic [VW-1:0]          scan_lvl_q;
	logic [1:0]             status_q;
	logic [VW-1:0]          top_q;
	logic [LW-1:0]          head_q;
	logic                   hv_q;
	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;

	logic [VW-1:0]          level_q  [NUM_TASKS];
	logic [1:0]             cond_q   [NUM_TASKS];
	logic [LW-1:0]          prev_q   [NUM_TASKS];
	logic [LW-1:0]          next_q   [NUM_TASKS];
	logic                   queued_q [NUM_TASKS];
	logic [LW-1:0]          qhead_q  [NUM_LEVELS];
	logic [LW-1:0]          qtail_q  [NUM_LEVELS];

	logic [7:0]             init_prio;
	logic [1:0]             init_raw;
	logic [VW-1:0]          init_lvl;
	logic [1:0]             in_np;
	logic [1:0]             in_tsk;
	logic [TW-1:0]          lk_tsk;
	logic [VW-1:0]          lk_lvl;
	logic [LW-1:0]          ap_last;
	logic                   ap_last_ok;
	logic [LW-1:0]          ul_prev;
	logic [LW-1:0]          ul_next;
	logic [LW-1:0]          scan_head;
	logic                   do_append;
	logic                   do_unlink;
	logic                   out_free;
	logic [1:0]             tstate;

	prqs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.init_prio (init_prio)
	);

	assign in_tsk = s_axis_tdata[4:3];
	assign in_np  = s_axis_tdata[6:5];

	assign init_raw = (32'(app_q) < 4) ? 2'(init_prio >> (32'(app_q) << 1)) : 2'd0;
	assign init_lvl = (32'(init_raw) >= NUM_LEVELS) ? TOP_LVL : VW'(init_raw);

	always_comb begin
		lk_tsk = tsk_q;
		lk_lvl = app_lvl_q;
		case (state_q)
			ST_INIT_APP: begin
				lk_tsk = app_q;
				lk_lvl = init_lvl;
			end
			ST_UNLINK: begin
				lk_lvl = level_q[tsk_q];
			end
			default: begin
				lk_lvl = app_lvl_q;
			end
		endcase
	end

	assign ap_last    = qtail_q[lk_lvl];
	assign ap_last_ok = ap_last < NONE;
	assign ul_prev    = prev_q[lk_tsk];
	assign ul_next    = next_q[lk_tsk];
	assign scan_head  = qhead_q[scan_lvl_q];
	assign do_append  = (state_q == ST_APPEND) || (state_q == ST_INIT_APP);
	assign do_unlink  = (state_q == ST_UNLINK);
	assign out_free   = !m_tvalid_q || m_axis_tready;
	assign tstate     = tsk_ok_q ? cond_q[tsk_q] : COND_WAIT;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_QUERY;
			tsk_q      <= '0;
			tsk_ok_q   <= 1'b0;
			np_q       <= '0;
			app_lvl_q  <= '0;
			app_q      <= '0;
			scan_lvl_q <= TOP_LVL;
			status_q   <= STATUS_OK;
			top_q      <= '0;
			head_q     <= '0;
			hv_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				level_q[i]  <= '0;
				cond_q[i]   <= COND_WAIT;
				prev_q[i]   <= NONE;
				next_q[i]   <= NONE;
				queued_q[i] <= 1'b0;
			end
			for (int i = 0; i < NUM_LEVELS; i++) begin
				qhead_q[i] <= NONE;
				qtail_q[i] <= NONE;
			end
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						mode_q   <= s_axis_tdata[2:0];
						tsk_q    <= TW'(in_tsk);
						tsk_ok_q <= 32'(in_tsk) < NUM_TASKS;
						np_q     <= (32'(in_np) >= NUM_LEVELS) ? TOP_LVL : VW'(in_np);
						status_q <= STATUS_OK;
						state_q  <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					scan_lvl_q <= TOP_LVL;
					case (mode_q)
						MODE_INIT: begin
							for (int i = 0; i < NUM_TASKS; i++) begin
								prev_q[i]   <= NONE;
								next_q[i]   <= NONE;
								queued_q[i] <= 1'b0;
							end
							for (int i = 0; i < NUM_LEVELS; i++) begin
								qhead_q[i] <= NONE;
								qtail_q[i] <= NONE;
							end
							app_q   <= '0;
							state_q <= ST_INIT_APP;
						end
						MODE_ADD: begin
							if (tsk_ok_q && !queued_q[tsk_q]) begin
								app_lvl_q <= level_q[tsk_q];
								state_q   <= ST_APPEND;
							end else begin
								if (tsk_ok_q) begin
									status_q <= STATUS_QUEUED;
								end
								state_q <= ST_SCAN;
							end
						end
						MODE_REMOVE, MODE_DELETE: begin
							if (tsk_ok_q && mode_q == MODE_DELETE) begin
								cond_q[tsk_q] <= COND_DORMANT;
							end
							if (tsk_ok_q && queued_q[tsk_q]) begin
								state_q <= ST_UNLINK;
							end else begin
								if (tsk_ok_q) begin
									status_q <= STATUS_NOT_QUEUED;
								end
								state_q <= ST_SCAN;
							end
						end
						MODE_CHANGE: begin
							if (tsk_ok_q && queued_q[tsk_q]) begin
								state_q <= ST_UNLINK;
							end else if (tsk_ok_q) begin
								level_q[tsk_q] <= np_q;
								app_lvl_q      <= np_q;
								state_q        <= ST_APPEND;
							end else begin
								state_q <= ST_SCAN;
							end
						end
						default: begin
							state_q <= ST_SCAN;
						end
					endcase
				end
				ST_INIT_APP: begin
					level_q[app_q] <= init_lvl;
					cond_q[app_q]  <= COND_READY;
					if (app_q == LAST_TSK) begin
						state_q <= ST_SCAN;
					end else begin
						app_q <= app_q + 1'b1;
					end
				end
				ST_UNLINK: begin
					if (mode_q == MODE_CHANGE) begin
						level_q[tsk_q] <= np_q;
						app_lvl_q      <= np_q;
						state_q        <= ST_APPEND;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_APPEND: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_head < NONE) begin
						top_q   <= scan_lvl_q;
						head_q  <= scan_head;
						hv_q    <= 1'b1;
						state_q <= ST_DONE;
					end else if (scan_lvl_q == VW'(1)) begin
						top_q   <= '0;
						head_q  <= '0;
						hv_q    <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						scan_lvl_q <= scan_lvl_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tdata_q <= {7'd0, tstate, hv_q, 2'(head_q), 2'(top_q), status_q};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (do_append) begin
				prev_q[lk_tsk]   <= ap_last;
				next_q[lk_tsk]   <= NONE;
				queued_q[lk_tsk] <= 1'b1;
				if (ap_last_ok) begin
					next_q[ap_last[TW-1:0]] <= LW'(lk_tsk);
				end else begin
					qhead_q[lk_lvl] <= LW'(lk_tsk);
				end
				qtail_q[lk_lvl] <= LW'(lk_tsk);
			end

			if (do_unlink) begin
				if (ul_prev < NONE) begin
					next_q[ul_prev[TW-1:0]] <= ul_next;
				end else begin
					qhead_q[lk_lvl] <= ul_next;
				end
				if (ul_next < NONE) begin
					prev_q[ul_next[TW-1:0]] <= ul_prev;
				end else begin
					qtail_q[lk_lvl] <= ul_prev;
				end
				prev_q[lk_tsk]   <= NONE;
				next_q[lk_tsk]   <= NONE;
				queued_q[lk_tsk] <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/prqs_checker.sv =====
// Port-level checker for the scheduler, bound to the top level.
module prqs_checker
	import prqs_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("command taken while previous one in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] == STATUS_OK ||
			m_axis_tdata[1:0] == STATUS_NOT_QUEUED || m_axis_tdata[1:0] == STATUS_QUEUED))
		else $error("undefined status code");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[6] |-> m_axis_tdata[5:2] == 4'd0)
		else $error("top level or head reported with no ready queue");

	a_top_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[3:2] != 2'd0)
		else $error("head reported at level zero");

endmodule

bind priority_ready_queue_scheduler_unit prqs_checker u_prqs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_priority_ready_queue_scheduler_unit.sv =====
// Testbench for the priority ready queue scheduler: stream commands checked against a local predictor.
`timescale 1ns / 100ps

module tb_priority_ready_queue_scheduler_unit;
	import prqs_pkg::*;

	localparam int TASKS          = 4;
	localparam int LEVELS         = 4;
	localparam logic [2:0] NO_LINK = 3'(TASKS);
	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;
	localparam logic [PADDR_W-1:0] ADDR_INIT_PRIO = PADDR_W'(4 * REG_INIT_PRIO);
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] top;
		logic [1:0] head;
		logic       valid;
		logic [1:0] state;
	} sched_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	// predictor state
	logic [7:0] init_prio_q;
	logic [1:0] level_q [TASKS];
	logic [1:0] cond_q [TASKS];
	logic [2:0] prev_q [TASKS];
	logic [2:0] next_q [TASKS];
	logic [2:0] head_q [LEVELS];
	logic [2:0] tail_q [LEVELS];
	bit         linked_q [TASKS];

	sched_result_t pending_results[$];
	sched_result_t want_r;

	int  errors;
	int  n_checked;
	int  n_cfg;
	int  mode_count [8];
	int  idle_cycles;
	int  ready_hold;
	bit  calm;

	priority_ready_queue_scheduler_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [1:0] clamp_level(int v);
		return (v >= LEVELS) ? 2'(LEVELS - 1) : 2'(v);
	endfunction

	function automatic void link_tail(int t);
		logic [2:0] last;
		last = tail_q[level_q[t]];
		prev_q[t] = last;
		next_q[t] = NO_LINK;
		if (last != NO_LINK) begin
			next_q[last] = 3'(t);
		end else begin
			head_q[level_q[t]] = 3'(t);
		end
		tail_q[level_q[t]] = 3'(t);
		linked_q[t] = 1'b1;
	endfunction

	function automatic void unlink(int t);
		logic [2:0] p;
		logic [2:0] n;
		p = prev_q[t];
		n = next_q[t];
		if (p != NO_LINK) begin
			next_q[p] = n;
		end else begin
			head_q[level_q[t]] = n;
		end
		if (n != NO_LINK) begin
			prev_q[n] = p;
		end else begin
			tail_q[level_q[t]] = p;
		end
		prev_q[t] = NO_LINK;
		next_q[t] = NO_LINK;
		linked_q[t] = 1'b0;
	endfunction

	function automatic void clear_queues();
		for (int i = 0; i < TASKS; i++) begin
			prev_q[i] = NO_LINK;
			next_q[i] = NO_LINK;
			linked_q[i] = 1'b0;
		end
		for (int i = 0; i < LEVELS; i++) begin
			head_q[i] = NO_LINK;
			tail_q[i] = NO_LINK;
		end
	endfunction

	function automatic sched_result_t sched_step(logic [2:0] mode, logic [1:0] tid,
			logic [1:0] np);
		sched_result_t r;
		int t;
		bit found;
		r = '0;
		t = tid;
		found = 1'b0;
		case (mode)
			MODE_INIT: begin
				clear_queues();
				for (int i = 0; i < TASKS; i++) begin
					level_q[i] = clamp_level(init_prio_q[2*i +: 2]);
					cond_q[i] = COND_READY;
					link_tail(i);
				end
			end
			MODE_ADD: begin
				if (linked_q[t]) r.status = STATUS_QUEUED;
				else link_tail(t);
			end
			MODE_REMOVE: begin
				if (linked_q[t]) unlink(t);
				else r.status = STATUS_NOT_QUEUED;
			end
			MODE_DELETE: begin
				if (linked_q[t]) unlink(t);
				else r.status = STATUS_NOT_QUEUED;
				cond_q[t] = COND_DORMANT;
			end
			MODE_CHANGE: begin
				if (linked_q[t]) unlink(t);
				level_q[t] = clamp_level(np);
				link_tail(t);
			end
			default: ;
		endcase
		for (int lv = LEVELS - 1; lv >= 1; lv--) begin
			if (!found && head_q[lv] != NO_LINK) begin
				found = 1'b1;
				r.top = 2'(lv);
				r.head = head_q[lv][1:0];
				r.valid = 1'b1;
			end
		end
		r.state = cond_q[t];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing pending, expected none, actual %h",
					$time, m_axis_tdata);
				errors++;
			end else begin
				want_r = pending_results.pop_front();
				check_field("status", want_r.status, m_axis_tdata[1:0]);
				check_field("top_priority", want_r.top, m_axis_tdata[3:2]);
				check_field("head_task", want_r.head, m_axis_tdata[5:4]);
				check_field("head_valid", want_r.valid, m_axis_tdata[6]);
				check_field("task_state", want_r.state, m_axis_tdata[8:7]);
			end
			n_checked++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (ready_hold > 0) begin
			m_axis_tready <= 1'b0;
			ready_hold--;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0) ready_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_cmd(logic [2:0] mode, logic [1:0] tid, logic [1:0] np);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, np, tid, mode};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(sched_step(mode, tid, np));
		mode_count[mode]++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() > 0) @(posedge clk);
	endtask

	task automatic quiesce();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_init_levels(logic [7:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_INIT_PRIO;
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		init_prio_q = value;
		n_cfg++;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		check_field("initial_priorities readback", init_prio_q, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_reset_readback();
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= ADDR_INIT_PRIO;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		check_field("initial_priorities after reset", INIT_PRIO_RESET, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_directed_ops();
		calm = 1'b0;
		send_cmd(MODE_QUERY, 2'd0, 2'd0);
		send_cmd(MODE_ADD, 2'd0, 2'd0);
		send_cmd(MODE_ADD, 2'd0, 2'd0);
		send_cmd(MODE_REMOVE, 2'd1, 2'd0);
		send_cmd(MODE_DELETE, 2'd1, 2'd0);
		send_cmd(MODE_CHANGE, 2'd2, 2'd3);
		send_cmd(MODE_CHANGE, 2'd3, 2'd3);
		send_cmd(MODE_CHANGE, 2'd1, 2'd1);
		send_cmd(MODE_REMOVE, 2'd2, 2'd0);
		send_cmd(MODE_CHANGE, 2'd2, 2'd3);
		send_cmd(MODE_REMOVE, 2'd2, 2'd0);
		send_cmd(MODE_DELETE, 2'd3, 2'd0);
		send_cmd(MODE_CHANGE, 2'd0, 2'd0);
		send_cmd(MODE_CHANGE, 2'd1, 2'd1);
		send_cmd(MODE_RSVD6, 2'd3, 2'd0);
		send_cmd(MODE_RSVD7, 2'd2, 2'd3);
		send_cmd(MODE_INIT, 2'd0, 2'd0);
		send_cmd(MODE_CHANGE, 2'd1, 2'd2);
		send_cmd(MODE_DELETE, 2'd2, 2'd0);
		send_cmd(MODE_ADD, 2'd2, 2'd0);
		send_cmd(MODE_REMOVE, 2'd3, 2'd0);
		send_cmd(MODE_QUERY, 2'd3, 2'd3);
		drain();
	endtask

	task automatic test_init_levels();
		logic [7:0] values [4];
		values = '{8'h00, 8'hFF, 8'hE4, 8'h1B};
		foreach (values[i]) begin
			quiesce();
			set_init_levels(values[i]);
			send_cmd(MODE_INIT, 2'($urandom), 2'($urandom));
			send_cmd(MODE_DELETE, 2'($urandom), 2'd0);
			send_cmd(MODE_QUERY, 2'($urandom), 2'($urandom));
		end
	endtask

	task automatic test_random_mix(int count);
		int r;
		logic [2:0] mode;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
			if (i == count / 2) drain();
			r = $urandom_range(0, 99);
			if (r < 22) mode = MODE_ADD;
			else if (r < 38) mode = MODE_REMOVE;
			else if (r < 48) mode = MODE_DELETE;
			else if (r < 72) mode = MODE_CHANGE;
			else if (r < 84) mode = MODE_QUERY;
			else if (r < 94) mode = MODE_INIT;
			else if (r < 97) mode = MODE_RSVD6;
			else mode = MODE_RSVD7;
			send_cmd(mode, 2'($urandom), 2'($urandom));
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		errors = 0;
		n_checked = 0;
		n_cfg = 0;
		idle_cycles = 0;
		ready_hold = 0;
		calm = 1'b0;
		foreach (mode_count[i]) mode_count[i] = 0;
		init_prio_q = INIT_PRIO_RESET;
		for (int i = 0; i < TASKS; i++) begin
			level_q[i] = 2'd0;
			cond_q[i] = COND_WAIT;
		end
		clear_queues();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_readback();
		test_directed_ops();
		test_init_levels();
		for (int phase = 0; phase < 4; phase++) begin
			quiesce();
			set_init_levels((phase == 0) ? INIT_PRIO_RESET : 8'($urandom));
			test_random_mix(225);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent add %0d, remove %0d, delete %0d, change %0d, query %0d, init %0d,",
			mode_count[MODE_ADD], mode_count[MODE_REMOVE], mode_count[MODE_DELETE],
			mode_count[MODE_CHANGE], mode_count[MODE_QUERY], mode_count[MODE_INIT]);
		$display("unused modes %0d; %0d results checked over %0d register settings",
			mode_count[MODE_RSVD6] + mode_count[MODE_RSVD7], n_checked, n_cfg);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/prqs_pkg.sv
hw/rtl/prqs_cfg_regs.sv
hw/rtl/priority_ready_queue_scheduler_unit.sv
hw/rtl/prqs_checker.sv
tb/tb_priority_ready_queue_scheduler_unit.sv
